// File: rtl/palette_fade_engine_assert.svh
`ifndef PALETTE_FADE_ENGINE_ASSERT_SVH
`define PALETTE_FADE_ENGINE_ASSERT_SVH

// Check sampled on clk and held off while rst_n is low.
`define PFE_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check sampled on clk that also holds across reset.
`define PFE_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/pfe_pkg.sv
package pfe_pkg;

  localparam int PALETTE_ENTRIES_DEF = 64;
  localparam int FADE_LAST_FRAME_DEF = 21;

  localparam logic [7:0] FADE_STEP   = 8'd32;
  localparam logic [7:0] FLASH_LEVEL = 8'd224;
  localparam logic [6:0] FULL_LAST   = 7'd63;

  localparam logic [2:0] CMD_WRITE_CUR = 3'd0;
  localparam logic [2:0] CMD_WRITE_TGT = 3'd1;
  localparam logic [2:0] CMD_READ_CUR  = 3'd2;
  localparam logic [2:0] CMD_START     = 3'd3;
  localparam logic [2:0] CMD_FRAME     = 3'd4;

  localparam logic [2:0] MODE_NONE      = 3'd0;
  localparam logic [2:0] MODE_FADE_IN   = 3'd1;
  localparam logic [2:0] MODE_FADE_OUT  = 3'd2;
  localparam logic [2:0] MODE_FLASH_IN  = 3'd3;
  localparam logic [2:0] MODE_FLASH_OUT = 3'd4;

  localparam logic [1:0] REG_FADE_MODE   = 2'd0;
  localparam logic [1:0] REG_FIRST_ENTRY = 2'd1;
  localparam logic [1:0] REG_ENTRY_SPAN  = 2'd2;
  localparam logic [1:0] REG_SKIP_BANK   = 2'd3;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_FILL,
    ST_STEP,
    ST_DRAIN
  } state_t;

  typedef struct packed {
    logic [2:0] command;
    logic       bank;
    logic [5:0] index;
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
  } in_item_t;

  typedef struct packed {
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic       fade_done;
  } out_item_t;

endpackage

// File: rtl/pfe_step.sv
module pfe_step (
  input  logic [2:0]  mode,
  input  logic [23:0] cur,
  input  logic [23:0] tgt,
  output logic [23:0] nxt
);

  logic [7:0] c_r, c_g, c_b;
  logic [7:0] t_r, t_g, t_b;
  logic [7:0] n_r, n_g, n_b;

  always_comb begin
    c_r = cur[23:16];
    c_g = cur[15:8];
    c_b = cur[7:0];
    t_r = tgt[23:16];
    t_g = tgt[15:8];
    t_b = tgt[7:0];
    n_r = c_r;
    n_g = c_g;
    n_b = c_b;
    unique case (mode)
      pfe_pkg::MODE_FADE_IN: begin
        if (t_b > c_b) n_b = c_b + pfe_pkg::FADE_STEP;
        else if (t_g > c_g) n_g = c_g + pfe_pkg::FADE_STEP;
        else if (t_r > c_r) n_r = c_r + pfe_pkg::FADE_STEP;
      end
      pfe_pkg::MODE_FADE_OUT: begin
        if (c_r != 8'd0) n_r = c_r - pfe_pkg::FADE_STEP;
        else if (c_g != 8'd0) n_g = c_g - pfe_pkg::FADE_STEP;
        else if (c_b != 8'd0) n_b = c_b - pfe_pkg::FADE_STEP;
      end
      pfe_pkg::MODE_FLASH_IN: begin
        if (t_b < c_b) n_b = c_b - pfe_pkg::FADE_STEP;
        else if (t_g < c_g) n_g = c_g - pfe_pkg::FADE_STEP;
        else if (t_r < c_r) n_r = c_r - pfe_pkg::FADE_STEP;
      end
      pfe_pkg::MODE_FLASH_OUT: begin
        if (c_r != pfe_pkg::FLASH_LEVEL) n_r = c_r + pfe_pkg::FADE_STEP;
        else if (c_g != pfe_pkg::FLASH_LEVEL) n_g = c_g + pfe_pkg::FADE_STEP;
        else if (c_b != pfe_pkg::FLASH_LEVEL) n_b = c_b + pfe_pkg::FADE_STEP;
      end
      default: begin
      end
    endcase
    nxt = {n_r, n_g, n_b};
  end

endmodule

// File: rtl/palette_fade_engine.sv
// Palette fade engine: two banks of current and target colours with a frame counter.
// Commands arrive on the in_ channel (valid/stall); each transfer gives exactly one
// result transfer on the out_ channel, held in an output register while out_stall is high.
// The user sets mode, range and bank skip (APB-style port) only while idle; not enforced.
// Path from input transfer to result valid:
//   write, unknown command, start with no fill, tick with no mode: the output register;
//   current entry read: the current memory read registered in ST_READ, output register;
//   start in fade-in or flash-in: ST_FILL sweeps entries in bank 0, output register;
//   frame tick: ST_STEP over entries first to last of each walked bank (both banks of
//   64 entries by default), ST_DRAIN, output register; the read-modify-write walk through
//   the current memory goes one entry a cycle.
// A new item is taken in the cycle its predecessor's result is taken, or later.
// After reset the current memory is swept to zero, all 2 * 2**clog2(PALETTE_ENTRIES)
// entries (128 by default), while in_stall stays high; configuration writes are taken.
// A stalled receiver holds the result in place and holds off further input.
module palette_fade_engine #(
  parameter int PALETTE_ENTRIES = pfe_pkg::PALETTE_ENTRIES_DEF,
  parameter int FADE_LAST_FRAME = pfe_pkg::FADE_LAST_FRAME_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  pfe_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output pfe_pkg::out_item_t out_data,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int EW    = $clog2(PALETTE_ENTRIES);
  localparam int AW    = EW + 1;
  localparam int DEPTH = 2 ** AW;
  localparam logic [8:0] LIMIT      = 9'(PALETTE_ENTRIES);
  localparam logic [5:0] LAST_FRAME = 6'(FADE_LAST_FRAME);

  pfe_pkg::state_t    state_r, state_nxt;
  logic [2:0]         mode_r;
  logic [5:0]         first_r;
  logic [5:0]         span_r;
  logic               skip_r;
  logic [4:0]         fc_r, fc_nxt;
  logic               walk_bank_r, walk_bank_nxt;
  logic [6:0]         walk_idx_r, walk_idx_nxt;
  logic [6:0]         walk_lo_r, walk_lo_nxt;
  logic [6:0]         walk_hi_r, walk_hi_nxt;
  logic               walk_two_r, walk_two_nxt;
  logic [2:0]         walk_mode_r, walk_mode_nxt;
  logic               fill_white_r, fill_white_nxt;
  logic               pend_done_r, pend_done_nxt;
  logic               rd_ok_r, rd_ok_nxt;
  logic [AW-1:0]      clr_addr_r, clr_addr_nxt;
  logic               p_valid_r, p_valid_nxt;
  logic               p_en_r, p_en_nxt;
  logic [AW-1:0]      p_addr_r, p_addr_nxt;
  logic               out_valid_r, out_valid_nxt;
  pfe_pkg::out_item_t out_data_r, out_data_nxt;

  logic [23:0]        cur_mem [DEPTH];
  logic [23:0]        tgt_mem [DEPTH];
  logic [23:0]        cur_rdata_r;
  logic [23:0]        tgt_rdata_r;
  logic               cur_we, tgt_we;
  logic [AW-1:0]      cur_waddr, rd_addr;
  logic [23:0]        cur_wdata;
  logic [23:0]        step_nxt;

  logic               in_fire;
  logic               cfg_wr;
  logic [8:0]         cmd_idx9, walk_idx9;
  logic               cmd_ok, walk_ok;
  logic [AW-1:0]      cmd_addr, walk_addr;
  logic [23:0]        cmd_rgb;
  logic [6:0]         fade_hi;
  logic               mode_act, mode_in;
  logic [5:0]         fc_inc;
  logic               res_load;
  pfe_pkg::out_item_t res_data;

  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite;
  assign in_stall = !rst_n || (state_r != pfe_pkg::ST_IDLE) || (out_valid_r && out_stall);
  assign in_fire  = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign cmd_idx9  = 9'(in_data.index);
  assign cmd_ok    = cmd_idx9 < LIMIT;
  assign cmd_addr  = {in_data.bank, cmd_idx9[EW-1:0]};
  assign cmd_rgb   = {in_data.red_in, in_data.green_in, in_data.blue_in};
  assign walk_idx9 = 9'(walk_idx_r);
  assign walk_ok   = walk_idx9 < LIMIT;
  assign walk_addr = {walk_bank_r, walk_idx9[EW-1:0]};
  assign fade_hi   = 7'(first_r) + 7'(span_r);
  assign mode_act  = (mode_r == pfe_pkg::MODE_FADE_IN) || (mode_r == pfe_pkg::MODE_FADE_OUT) ||
                     (mode_r == pfe_pkg::MODE_FLASH_IN) || (mode_r == pfe_pkg::MODE_FLASH_OUT);
  assign mode_in   = (mode_r == pfe_pkg::MODE_FADE_IN) || (mode_r == pfe_pkg::MODE_FLASH_IN);
  assign fc_inc    = 6'(fc_r) + 6'd1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= pfe_pkg::MODE_NONE;
      first_r <= 6'd0;
      span_r  <= 6'd63;
      skip_r  <= 1'b0;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        pfe_pkg::REG_FADE_MODE:   mode_r  <= pwdata[2:0];
        pfe_pkg::REG_FIRST_ENTRY: first_r <= pwdata[5:0];
        pfe_pkg::REG_ENTRY_SPAN:  span_r  <= pwdata[5:0];
        pfe_pkg::REG_SKIP_BANK:   skip_r  <= pwdata[0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      pfe_pkg::REG_FADE_MODE:   prdata = 32'(mode_r);
      pfe_pkg::REG_FIRST_ENTRY: prdata = 32'(first_r);
      pfe_pkg::REG_ENTRY_SPAN:  prdata = 32'(span_r);
      pfe_pkg::REG_SKIP_BANK:   prdata = 32'(skip_r);
      default:                  prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cur_we) begin
      cur_mem[cur_waddr] <= cur_wdata;
    end
    cur_rdata_r <= cur_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (tgt_we) begin
      tgt_mem[cmd_addr] <= cmd_rgb;
    end
    tgt_rdata_r <= tgt_mem[rd_addr];
  end

  pfe_step u_step (
    .mode (walk_mode_r),
    .cur  (cur_rdata_r),
    .tgt  (tgt_rdata_r),
    .nxt  (step_nxt)
  );

  always_comb begin
    state_nxt      = state_r;
    fc_nxt         = fc_r;
    walk_bank_nxt  = walk_bank_r;
    walk_idx_nxt   = walk_idx_r;
    walk_lo_nxt    = walk_lo_r;
    walk_hi_nxt    = walk_hi_r;
    walk_two_nxt   = walk_two_r;
    walk_mode_nxt  = walk_mode_r;
    fill_white_nxt = fill_white_r;
    pend_done_nxt  = pend_done_r;
    rd_ok_nxt      = rd_ok_r;
    clr_addr_nxt   = clr_addr_r;
    p_valid_nxt    = 1'b0;
    p_en_nxt       = p_en_r;
    p_addr_nxt     = p_addr_r;
    rd_addr        = cmd_addr;
    cur_we         = p_valid_r && p_en_r;
    cur_waddr      = p_addr_r;
    cur_wdata      = step_nxt;
    tgt_we         = 1'b0;
    res_load       = 1'b0;
    res_data       = '0;

    unique case (state_r)
      pfe_pkg::ST_CLEAR: begin
        cur_we       = 1'b1;
        cur_waddr    = clr_addr_r;
        cur_wdata    = 24'd0;
        clr_addr_nxt = clr_addr_r + 1'b1;
        if (&clr_addr_r) state_nxt = pfe_pkg::ST_IDLE;
      end
      pfe_pkg::ST_IDLE: begin
        if (in_fire) begin
          unique case (in_data.command)
            pfe_pkg::CMD_WRITE_CUR: begin
              cur_we    = cmd_ok;
              cur_waddr = cmd_addr;
              cur_wdata = cmd_rgb;
              res_load  = 1'b1;
            end
            pfe_pkg::CMD_WRITE_TGT: begin
              tgt_we   = cmd_ok;
              res_load = 1'b1;
            end
            pfe_pkg::CMD_READ_CUR: begin
              rd_ok_nxt = cmd_ok;
              state_nxt = pfe_pkg::ST_READ;
            end
            pfe_pkg::CMD_START: begin
              fc_nxt = 5'd0;
              pend_done_nxt = 1'b0;
              if (mode_r == pfe_pkg::MODE_FADE_IN) begin
                walk_idx_nxt   = 7'(first_r);
                walk_hi_nxt    = fade_hi;
                fill_white_nxt = 1'b0;
                state_nxt      = pfe_pkg::ST_FILL;
              end else if (mode_r == pfe_pkg::MODE_FLASH_IN) begin
                walk_idx_nxt   = 7'd0;
                walk_hi_nxt    = pfe_pkg::FULL_LAST;
                fill_white_nxt = 1'b1;
                state_nxt      = pfe_pkg::ST_FILL;
              end else begin
                res_load = 1'b1;
              end
            end
            pfe_pkg::CMD_FRAME: begin
              if (!mode_act) begin
                res_load           = 1'b1;
                res_data.fade_done = 1'b1;
              end else begin
                walk_bank_nxt = 1'b0;
                walk_mode_nxt = mode_r;
                walk_two_nxt  = !(mode_in && skip_r);
                if (mode_r == pfe_pkg::MODE_FADE_IN) begin
                  walk_lo_nxt  = 7'(first_r);
                  walk_idx_nxt = 7'(first_r);
                  walk_hi_nxt  = fade_hi;
                end else begin
                  walk_lo_nxt  = 7'd0;
                  walk_idx_nxt = 7'd0;
                  walk_hi_nxt  = pfe_pkg::FULL_LAST;
                end
                if (fc_inc > LAST_FRAME) begin
                  fc_nxt        = 5'd0;
                  pend_done_nxt = 1'b1;
                end else begin
                  fc_nxt        = fc_inc[4:0];
                  pend_done_nxt = 1'b0;
                end
                state_nxt = pfe_pkg::ST_STEP;
              end
            end
            default: begin
              res_load = 1'b1;
            end
          endcase
        end
      end
      pfe_pkg::ST_READ: begin
        res_load = 1'b1;
        if (rd_ok_r) begin
          res_data.red_out   = cur_rdata_r[23:16];
          res_data.green_out = cur_rdata_r[15:8];
          res_data.blue_out  = cur_rdata_r[7:0];
        end
        state_nxt = pfe_pkg::ST_IDLE;
      end
      pfe_pkg::ST_FILL: begin
        cur_we    = walk_ok;
        cur_waddr = {1'b0, walk_idx9[EW-1:0]};
        cur_wdata = fill_white_r ? {3{pfe_pkg::FLASH_LEVEL}} : 24'd0;
        if (walk_idx_r == walk_hi_r) begin
          res_load  = 1'b1;
          state_nxt = pfe_pkg::ST_IDLE;
        end else begin
          walk_idx_nxt = walk_idx_r + 7'd1;
        end
      end
      pfe_pkg::ST_STEP: begin
        rd_addr     = walk_addr;
        p_valid_nxt = 1'b1;
        p_en_nxt    = walk_ok;
        p_addr_nxt  = walk_addr;
        if (walk_idx_r == walk_hi_r) begin
          if (walk_two_r && !walk_bank_r) begin
            walk_bank_nxt = 1'b1;
            walk_idx_nxt  = walk_lo_r;
          end else begin
            state_nxt = pfe_pkg::ST_DRAIN;
          end
        end else begin
          walk_idx_nxt = walk_idx_r + 7'd1;
        end
      end
      pfe_pkg::ST_DRAIN: begin
        res_load           = 1'b1;
        res_data.fade_done = pend_done_r;
        state_nxt          = pfe_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = pfe_pkg::ST_CLEAR;
      end
    endcase

    out_valid_nxt = res_load || (out_valid_r && out_stall);
    out_data_nxt  = res_load ? res_data : out_data_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pfe_pkg::ST_CLEAR;
      fc_r        <= 5'd0;
      clr_addr_r  <= '0;
      p_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fc_r        <= fc_nxt;
      clr_addr_r  <= clr_addr_nxt;
      p_valid_r   <= p_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    walk_bank_r  <= walk_bank_nxt;
    walk_idx_r   <= walk_idx_nxt;
    walk_lo_r    <= walk_lo_nxt;
    walk_hi_r    <= walk_hi_nxt;
    walk_two_r   <= walk_two_nxt;
    walk_mode_r  <= walk_mode_nxt;
    fill_white_r <= fill_white_nxt;
    pend_done_r  <= pend_done_nxt;
    rd_ok_r      <= rd_ok_nxt;
    p_en_r       <= p_en_nxt;
    p_addr_r     <= p_addr_nxt;
    out_data_r   <= out_data_nxt;
  end

endmodule

// File: rtl/pfe_checker.sv
`include "palette_fade_engine_assert.svh"

module pfe_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input pfe_pkg::out_item_t out_data
);

  logic out_held;
  logic in_take;
  logic done_out;
  logic no_colour;

  assign out_held  = out_valid && out_stall;
  assign in_take   = in_valid && !in_stall;
  assign done_out  = out_valid && out_data.fade_done;
  assign no_colour = {out_data.red_out, out_data.green_out, out_data.blue_out} == 24'd0;

  `PFE_ASSERT(a_out_valid_held, out_held |=> out_valid, "result dropped while stalled")
  `PFE_ASSERT(a_out_data_held, out_held |=> $stable(out_data), "stalled result changed")
  `PFE_ASSERT(a_one_at_a_time, in_take |=> out_valid || in_stall, "input taken too early")
  `PFE_ASSERT(a_done_no_colour, done_out |-> no_colour, "done result carries colour")
  `PFE_ASSERT_ALWAYS(a_clear_after_reset, !$past(rst_n) && rst_n |-> in_stall, "input not stalled")

endmodule

bind palette_fade_engine pfe_checker u_pfe_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
